@@ src/kctmea_pkg.sv @@
// kctmea_pkg: shared types and constants for the keyed claim table arbiter
`timescale 1ns / 1ps

package kctmea_pkg;

   // field widths
   localparam int KEY_W  = 32;
   localparam int ETA_W  = 16;
   localparam int DIST_W = 16;
   localparam int ARM_W  = 4;
   localparam int CSR_W  = 15;

   // configuration register indexes
   localparam logic CSR_CLEAR_DISTANCE   = 1'b0;
   localparam logic CSR_TRIGGER_DISTANCE = 1'b1;

   // register reset values
   localparam logic [CSR_W-1:0] CLEAR_DISTANCE_RST   = 15'd200;
   localparam logic [CSR_W-1:0] TRIGGER_DISTANCE_RST = 15'd3000;

   // one stored claim
   typedef struct packed {
      logic [KEY_W-1:0]         key;
      logic [ETA_W-1:0]         eta;
      logic signed [DIST_W-1:0] dist_ahead;
      logic [ARM_W-1:0]         arm;
   } entry_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_WRITE  = 5'b00100,
      ST_ARB    = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

endpackage

@@ src/keyed_claim_table_min_eta_arbiter.sv @@
// keyed_claim_table_min_eta_arbiter: claim table with least-eta arbitration
`timescale 1ns / 1ps

// Each request beat carries one vehicle report. The block walks its claim table
// twice through an entry memory with one write and one registered read: the first
// pass finds the active entry holding the key or else the lowest free entry, then
// the report is written there (dropped when the table is full); the second pass
// frees entries at or beyond minus clear_distance and picks the in-zone entry with
// the least eta, lowest index on ties. No new report is taken until the current
// one is answered: req_ready is low from accept through both memory passes until
// the response beat is taken. The response beat holds until rsp_ready.
// Configuration writes take effect at once and should be made while no item is
// in flight.
module keyed_claim_table_min_eta_arbiter #(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [kctmea_pkg::KEY_W-1:0]       req_vehicle_key,
   input  logic [kctmea_pkg::ETA_W-1:0]       req_eta,
   input  logic signed [kctmea_pkg::DIST_W-1:0] req_distance_ahead,
   input  logic [kctmea_pkg::ARM_W-1:0]       req_arm,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_has_winner,
   output logic [kctmea_pkg::ARM_W-1:0]       rsp_winner_arm,
   // configuration port
   input  logic                               csr_write_en,
   input  logic                               csr_index,
   input  logic [kctmea_pkg::CSR_W-1:0]       csr_wdata
);
   import kctmea_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int CMP_W = DIST_W + 1;

   // sequencer and scan registers
   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          iss_ff, iss_in;
   logic                      chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]          chk_idx_ff, chk_idx_in;
   logic [TABLE_ENTRIES-1:0]  active_ff, active_in;
   logic                      match_vld_ff, match_vld_in;
   logic [IDX_W-1:0]          match_idx_ff, match_idx_in;
   logic                      free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]          free_idx_ff, free_idx_in;
   logic                      best_vld_ff, best_vld_in;
   logic [ETA_W-1:0]          best_eta_ff, best_eta_in;
   logic [ARM_W-1:0]          best_arm_ff, best_arm_in;
   logic                      has_winner_ff, has_winner_in;
   logic [ARM_W-1:0]          winner_arm_ff, winner_arm_in;
   logic [CSR_W-1:0]          clear_ff, trig_ff;

   // latched request
   entry_type                 req_ff;

   // entry memory
   entry_type                 mem [TABLE_ENTRIES];
   entry_type                 rd_data_ff;
   logic [IDX_W-1:0]          rd_addr;
   logic                      mem_we;
   logic [IDX_W-1:0]          wr_addr;

   // shared compare unit
   logic signed [CMP_W-1:0]   neg_clear;
   logic signed [CMP_W-1:0]   trig_ext;
   logic signed [DIST_W-1:0]  cmp_dist;
   logic signed [CMP_W-1:0]   cmp_dist_ext;
   logic                      is_clearable;
   logic                      in_trigger;
   logic                      eta_less;
   logic                      key_equal;
   logic                      chk_last;

   assign neg_clear    = -$signed({2'b00, clear_ff});
   assign trig_ext     = $signed({2'b00, trig_ff});
   assign cmp_dist     = (state_ff == ST_WRITE) ? req_ff.dist_ahead : rd_data_ff.dist_ahead;
   assign cmp_dist_ext = {cmp_dist[DIST_W-1], cmp_dist};
   assign is_clearable = (cmp_dist_ext <= neg_clear);
   assign in_trigger   = (cmp_dist_ext <= trig_ext);
   assign eta_less     = (rd_data_ff.eta < best_eta_ff);
   assign key_equal    = (rd_data_ff.key == req_ff.key);
   assign chk_last     = (chk_idx_ff == IDX_W'(TABLE_ENTRIES - 1));

   // read address follows the issue counter
   assign rd_addr = (iss_ff < CNT_W'(TABLE_ENTRIES)) ? iss_ff[IDX_W-1:0] : '0;
   assign wr_addr = match_vld_ff ? match_idx_ff : free_idx_ff;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = (state_ff == ST_RESP);
   assign rsp_has_winner = has_winner_ff;
   assign rsp_winner_arm = winner_arm_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      iss_in        = iss_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      active_in     = active_ff;
      match_vld_in  = match_vld_ff;
      match_idx_in  = match_idx_ff;
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      best_vld_in   = best_vld_ff;
      best_eta_in   = best_eta_ff;
      best_arm_in   = best_arm_ff;
      has_winner_in = has_winner_ff;
      winner_arm_in = winner_arm_ff;
      mem_we        = 1'b0;

      // issue the next table read during a pass
      if ((state_ff == ST_LOOKUP || state_ff == ST_ARB) &&
          iss_ff < CNT_W'(TABLE_ENTRIES)) begin
         chk_vld_in = 1'b1;
         chk_idx_in = iss_ff[IDX_W-1:0];
         iss_in     = iss_ff + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in     = ST_LOOKUP;
               iss_in       = '0;
               match_vld_in = 1'b0;
               free_vld_in  = 1'b0;
            end
         end
         ST_LOOKUP: begin
            if (chk_vld_ff) begin
               if (active_ff[chk_idx_ff]) begin
                  if (!match_vld_ff && key_equal) begin
                     match_vld_in = 1'b1;
                     match_idx_in = chk_idx_ff;
                  end
               end else if (!free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (chk_last) begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            // store the report, freed at once when already past the clear line
            if (match_vld_ff || free_vld_ff) begin
               mem_we             = 1'b1;
               active_in[wr_addr] = !is_clearable;
            end
            iss_in      = '0;
            best_vld_in = 1'b0;
            state_in    = ST_ARB;
         end
         ST_ARB: begin
            if (chk_vld_ff) begin
               if (active_ff[chk_idx_ff]) begin
                  if (is_clearable) begin
                     active_in[chk_idx_ff] = 1'b0;
                  end else if (in_trigger && (!best_vld_ff || eta_less)) begin
                     best_vld_in = 1'b1;
                     best_eta_in = rd_data_ff.eta;
                     best_arm_in = rd_data_ff.arm;
                  end
               end
               if (chk_last) begin
                  has_winner_in = best_vld_in;
                  winner_arm_in = best_vld_in ? best_arm_in : '0;
                  state_in      = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         active_ff    <= '0;
         match_vld_ff <= 1'b0;
         free_vld_ff  <= 1'b0;
         best_vld_ff  <= 1'b0;
         clear_ff     <= CLEAR_DISTANCE_RST;
         trig_ff      <= TRIGGER_DISTANCE_RST;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         chk_vld_ff   <= chk_vld_in;
         active_ff    <= active_in;
         match_vld_ff <= match_vld_in;
         free_vld_ff  <= free_vld_in;
         best_vld_ff  <= best_vld_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_CLEAR_DISTANCE:   clear_ff <= csr_wdata;
               CSR_TRIGGER_DISTANCE: trig_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      match_idx_ff  <= match_idx_in;
      free_idx_ff   <= free_idx_in;
      best_eta_ff   <= best_eta_in;
      best_arm_ff   <= best_arm_in;
      has_winner_ff <= has_winner_in;
      winner_arm_ff <= winner_arm_in;
      if (req_valid && req_ready) begin
         req_ff.key        <= req_vehicle_key;
         req_ff.eta        <= req_eta;
         req_ff.dist_ahead <= req_distance_ahead;
         req_ff.arm        <= req_arm;
      end
   end

   // entry memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

@@ src/kctmea_checker.sv @@
// kctmea_checker: port-level assertions for the claim table arbiter
`timescale 1ns / 1ps

module kctmea_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_has_winner,
   input logic [kctmea_pkg::ARM_W-1:0] rsp_winner_arm
);
   import kctmea_pkg::*;

   // one item at a time: no new request while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("request ready while response pending");

   // an accepted request closes the request side
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
      else $error("request side open right after accept");

   // no winner means arm zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_winner) |-> (rsp_winner_arm == '0))
      else $error("winner arm set without a winner");

   // a stalled response beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_has_winner) && $stable(rsp_winner_arm)))
      else $error("response beat changed while stalled");

   // no second response beat: the beat ends once taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("second response beat without a request");

endmodule

bind keyed_claim_table_min_eta_arbiter kctmea_checker u_kctmea_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_has_winner (rsp_has_winner),
   .rsp_winner_arm (rsp_winner_arm)
);
